// ===== design/pcm_be_to_float32_converter_defines.svh =====
// Assertion macros shared by the converter modules.
`ifndef PCM_BE_TO_FLOAT32_CONVERTER_DEFINES_SVH
`define PCM_BE_TO_FLOAT32_CONVERTER_DEFINES_SVH
`ifndef SYNTHESIS
`define PBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PBF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/pbf_pkg.sv =====
// Package with shared types and the float conversion function.
`timescale 1ns / 1ps
package pbf_pkg;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_sample;

    // Exact single-precision bits of word * 2^-31; the low 8 bits are zero.
    function automatic logic [31:0] scaled_bits(input logic [31:0] word);
        logic [31:0] mag;
        logic [4:0]  top;
        logic [31:0] norm;
        logic [7:0]  expo;
        mag = word[31] ? (32'd0 - word) : word;
        top = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) top = 5'(i);
        end
        norm = mag << (5'd31 - top);
        expo = 8'(top) + 8'd96;
        if (mag == 32'd0) begin
            return 32'd0;
        end
        return {word[31], expo, norm[30:8]};
    endfunction
endpackage

// ===== design/pbf_front.sv =====
// Byte assembly: collects big-endian bytes into left-justified sample words.
`timescale 1ns / 1ps
module pbf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_depth_select,
    input  logic             i_cfg_write,
    input  logic             i_take,
    input  logic [7:0]       i_data_byte,
    input  logic             i_frame_start,
    input  logic             i_frame_end,
    output logic             o_push,
    output pbf_pkg::t_sample o_sample
);
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_partial, n_partial;
    logic [1:0]  w_phase;
    logic [1:0]  w_need;

    always_comb begin
        w_need   = i_depth_select ? 2'd3 : 2'd2;
        w_phase  = i_frame_start ? 2'd0 : r_phase;
        n_phase  = r_phase;
        n_partial = r_partial;
        o_push   = 1'b0;
        o_sample.last = i_frame_end;
        if (i_depth_select) begin
            o_sample.word = {r_partial, i_data_byte, 8'd0};
        end else begin
            o_sample.word = {r_partial[7:0], i_data_byte, 16'd0};
        end
        if (i_cfg_write) begin
            n_phase = 2'd0;
            n_partial = 16'd0;
        end else if (i_take) begin
            if ({1'b0, w_phase} + 3'd1 < {1'b0, w_need}) begin
                n_partial = {r_partial[7:0], i_data_byte};
                n_phase = w_phase + 2'd1;
            end else begin
                o_push = 1'b1;
                n_phase = 2'd0;
                n_partial = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_partial <= 16'd0;
        end else begin
            r_phase <= n_phase;
            r_partial <= n_partial;
        end
    end
endmodule

// ===== design/pbf_queue.sv =====
// Two-entry queue between the assembly and conversion parts.
`timescale 1ns / 1ps
`include "pcm_be_to_float32_converter_defines.svh"
module pbf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pbf_pkg::t_sample i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output pbf_pkg::t_sample o_data
);
    pbf_pkg::t_sample r_mem [pbf_pkg::QueueDepth];
    logic r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(pbf_pkg::QueueDepth));
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    `PBF_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, o_full, !i_push || i_pop)
    `PBF_ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `PBF_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !i_push && !i_pop, $stable(r_count))
endmodule

// ===== design/pbf_back.sv =====
// Conversion stage: turns a sample word into float bits in an output register.
`timescale 1ns / 1ps
`include "pcm_be_to_float32_converter_defines.svh"
module pbf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pbf_pkg::t_sample i_sample,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [31:0]      o_float_bits,
    output logic             o_last_in_frame
);
    logic        r_valid;
    logic [31:0] r_bits;
    logic        r_last;

    assign o_pop = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_float_bits = r_bits;
    assign o_last_in_frame = r_last;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= pbf_pkg::scaled_bits(i_sample.word);
            r_last <= i_sample.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    `PBF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_bits))
    `PBF_ASSERT_NEXT(a_load, i_clk, i_rst_n, o_pop, r_valid)
endmodule

// ===== design/pcm_be_to_float32_converter.sv =====
// Top level of the big-endian PCM byte to float32 converter.
//
//  channel | direction | handshake             | payload
//  input   | in        | i_valid / o_ready     | i_data_byte, i_frame_start, i_frame_end
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_depth_select
//  output  | out       | o_valid / i_ready     | o_float_bits, o_last_in_frame
//
// One byte is accepted per cycle while the queue is not full; a completed sample
// is written into the queue first and then into the output register.
// Throughput is set by the two-entry queue: bytes stall only when it is full.
// Reset is synchronous and clears depth, byte phase and all valid flags.
`timescale 1ns / 1ps
module pcm_be_to_float32_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    input  logic        i_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_depth_select,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_float_bits,
    output logic        o_last_in_frame
);
    logic r_depth;
    logic w_cfg_write, w_take, w_push, w_full, w_qvalid, w_pop;
    pbf_pkg::t_sample w_sample, w_qdata;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid;
    assign o_ready = !w_full;
    assign w_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= 1'b0;
        end else if (w_cfg_write) begin
            r_depth <= i_cfg_depth_select;
        end
    end

    pbf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_depth_select(r_depth),
        .i_cfg_write(w_cfg_write), .i_take(w_take), .i_data_byte(i_data_byte),
        .i_frame_start(i_frame_start), .i_frame_end(i_frame_end),
        .o_push(w_push), .o_sample(w_sample)
    );

    pbf_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_sample),
        .o_full(w_full), .o_valid(w_qvalid), .i_pop(w_pop), .o_data(w_qdata)
    );

    pbf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qvalid), .i_sample(w_qdata),
        .o_pop(w_pop), .o_valid(o_valid), .i_ready(i_ready),
        .o_float_bits(o_float_bits), .o_last_in_frame(o_last_in_frame)
    );
endmodule
